FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
// Both forms sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds.
`define TSRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tsrc assertion failed");
// Check that a condition is never true.
`define TSRC_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tsrc forbidden condition seen");
`else
`define TSRC_ASSERT(lbl, prop)
`define TSRC_NEVER(lbl, cond)
`endif
`endif

FILE: rtl/core/tsrc_pkg.sv
`timescale 1ns / 1ps
package tsrc_pkg;

  // Field and datapath widths
  localparam int COORD_W = 12;             // touch and config coordinates
  localparam int DIFF_W  = COORD_W + 1;    // signed offset from center
  localparam int SQ_W    = 2 * COORD_W + 1; // dx*dx + dy*dy
  localparam int RAD_W   = SQ_W + 1;       // radicand padded to even width
  localparam int LEN_W   = RAD_W / 2;      // floored root
  localparam int Q_W     = 15;             // quotient, at most full scale
  localparam int STICK_W = 16;             // signed Q1.14 output
  localparam int CNT_W   = 4;              // step counters of serial units

  // Step counts of the serial units
  localparam int SQ_STEPS  = COORD_W;
  localparam int RT_STEPS  = LEN_W;
  localparam int DIV_STEPS = Q_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_RAD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_RAD = 2'd3;

  localparam logic [COORD_W-1:0] STICK_RAD_RESET = 12'd128;

  // Event codes
  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_DOWN = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UP   = 2'd2;

  localparam logic signed [STICK_W-1:0] FULL_SCALE = 16'sd16384;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQSUM,
    ST_ROOT,
    ST_DIVIDE,
    ST_DONE
  } tsrc_state_t;

endpackage

FILE: rtl/core/tsrc_in_if.sv
`timescale 1ns / 1ps
interface tsrc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsrc_pkg::ACT_W-1:0]    action;
  logic [tsrc_pkg::COORD_W-1:0]  touch_x;
  logic [tsrc_pkg::COORD_W-1:0]  touch_y;

  modport source (output valid, action, touch_x, touch_y, input ready);
  modport sink (input valid, action, touch_x, touch_y, output ready);
endinterface

FILE: rtl/core/tsrc_out_if.sv
`timescale 1ns / 1ps
interface tsrc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsrc_pkg::STICK_W-1:0] stick_x;
  logic signed [tsrc_pkg::STICK_W-1:0] stick_y;
  logic                                is_pressed;

  modport source (output valid, stick_x, stick_y, is_pressed, input ready);
  modport sink (input valid, stick_x, stick_y, is_pressed, output ready);
endinterface

FILE: rtl/core/tsrc_sqsum.sv
`timescale 1ns / 1ps
// Sum of two squares by shift and add, one multiplier bit of each per cycle.
module tsrc_sqsum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tsrc_pkg::COORD_W-1:0] mag_x,
  input  logic [tsrc_pkg::COORD_W-1:0] mag_y,
  output logic                         done,
  output logic [tsrc_pkg::SQ_W-1:0]    sq
);
  import tsrc_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COORD_W-1:0] mx_r, mx_nxt;
  logic [COORD_W-1:0] my_r, my_nxt;
  logic [COORD_W-1:0] bx_r, bx_nxt;
  logic [COORD_W-1:0] by_r, by_nxt;
  logic [SQ_W-1:0]    acc_r, acc_nxt;
  logic [SQ_W-1:0]    add_x, add_y;

  // Pick the partial products for the current multiplier bits, MSB first
  always_comb begin
    add_x = bx_r[COORD_W-1] ? SQ_W'(mx_r) : '0;
    add_y = by_r[COORD_W-1] ? SQ_W'(my_r) : '0;
  end

  // Load on start, then shift the accumulator and add one digit a cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mx_nxt   = mx_r;
    my_nxt   = my_r;
    bx_nxt   = bx_r;
    by_nxt   = by_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(SQ_STEPS);
      mx_nxt   = mag_x;
      my_nxt   = mag_y;
      bx_nxt   = mag_x;
      by_nxt   = mag_y;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = {acc_r[SQ_W-2:0], 1'b0} + add_x + add_y;
      bx_nxt  = {bx_r[COORD_W-2:0], 1'b0};
      by_nxt  = {by_r[COORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    bx_r  <= bx_nxt;
    by_r  <= by_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign sq   = acc_r;
endmodule

FILE: rtl/core/tsrc_sqrt.sv
`timescale 1ns / 1ps
// Floored square root, two radicand bits in and one root bit out per cycle.
module tsrc_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tsrc_pkg::SQ_W-1:0]    sq,
  output logic                         done,
  output logic [tsrc_pkg::LEN_W-1:0]   root
);
  import tsrc_pkg::*;

  localparam int REM_W = LEN_W + 1;
  localparam int SH_W  = REM_W + 2;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] root_r, root_nxt;
  logic [SH_W-1:0]  rem_sh;
  logic [SH_W-1:0]  trial;
  logic             fits;

  // Bring in the next bit pair and test the trial subtrahend
  always_comb begin
    rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(RT_STEPS);
      rad_nxt  = RAD_W'(sq);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem_nxt  = REM_W'(rem_sh - trial);
        root_nxt = {root_r[LEN_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(rem_sh);
        root_nxt = {root_r[LEN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

FILE: rtl/core/tsrc_div.sv
`timescale 1ns / 1ps
// Restoring divider lane: mag * 2^14 / divisor, one quotient bit per cycle.
// Needs mag <= divisor, so the quotient never passes full scale.
module tsrc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tsrc_pkg::COORD_W-1:0] mag,
  input  logic [tsrc_pkg::LEN_W-1:0]   divisor,
  output logic                         done,
  output logic [tsrc_pkg::Q_W-1:0]     quot
);
  import tsrc_pkg::*;

  localparam int PART_W = LEN_W + 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              first_r, first_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  div_r, div_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [PART_W-1:0] part;
  logic              ge;

  // First step takes the magnitude as is, later ones shift in a zero
  always_comb begin
    part = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge   = (part >= {1'b0, div_r});
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    if (start) begin
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
      cnt_nxt   = CNT_W'(DIV_STEPS);
      div_nxt   = divisor;
      rem_nxt   = LEN_W'(mag);
      q_nxt     = '0;
    end else if (busy_r) begin
      first_nxt = 1'b0;
      rem_nxt   = ge ? LEN_W'(part - {1'b0, div_r}) : LEN_W'(part);
      q_nxt     = {q_r[Q_W-2:0], ge};
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

FILE: rtl/core/touch_stick_radial_clamp_top.sv
`timescale 1ns / 1ps
// Flow: a tracked down or move runs the square sum, the root and the two divide lanes in turn,
// then waits in the done state for the output; inside the dead zone the divide is skipped.
// Up, move while released and the unused code go from accept straight to the done state.
// Throughput: one item at a time; a new item is taken only once the last result is in the output register.
// Reset: synchronous active-low rst_n clears the stick and the pressed flag and restores the
// config defaults.
`include "assert_macros.svh"
module touch_stick_radial_clamp_top (
  input  logic                           clk,
  input  logic                           rst_n,
  tsrc_in_if.sink                        in_ch,
  tsrc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tsrc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tsrc_pkg::COORD_W-1:0]   cfg_wdata
);
  import tsrc_pkg::*;

  tsrc_state_t state_r, state_nxt;

  logic [COORD_W-1:0] cx_r, cy_r, rad_r, dead_r;

  logic                      held_r, held_nxt;
  logic signed [STICK_W-1:0] defx_r, defx_nxt;
  logic signed [STICK_W-1:0] defy_r, defy_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic               trk_r, trk_nxt;
  logic               clr_r, clr_nxt;
  logic               zero_r, zero_nxt;
  logic               sgnx_r, sgnx_nxt, sgny_r, sgny_nxt;
  logic [COORD_W-1:0] magx_r, magx_nxt, magy_r, magy_nxt;

  logic [DIFF_W-1:0] dx, dy;
  logic              accept;
  logic              out_free;
  logic              sq_start, rt_start, dv_start, fire;
  logic              sq_done, rt_done, dvx_done, dvy_done;
  logic [SQ_W-1:0]   sq;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  divisor;
  logic [Q_W-1:0]    qx, qy;
  logic              dead_hit;
  logic              tracks;

  // Take config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      rad_r  <= STICK_RAD_RESET;
      dead_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CENTER_X:  cx_r   <= cfg_wdata;
        CFG_CENTER_Y:  cy_r   <= cfg_wdata;
        CFG_STICK_RAD: rad_r  <= cfg_wdata;
        CFG_DEAD_RAD:  dead_r <= cfg_wdata;
      endcase
    end
  end

  // Offset from center, split into sign and magnitude
  always_comb begin
    dx       = {1'b0, in_ch.touch_x} - {1'b0, cx_r};
    dy       = {1'b0, in_ch.touch_y} - {1'b0, cy_r};
    sgnx_nxt = dx[DIFF_W-1];
    sgny_nxt = dy[DIFF_W-1];
    magx_nxt = dx[DIFF_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
    magy_nxt = dy[DIFF_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign tracks   = (in_ch.action == ACT_DOWN) || ((in_ch.action == ACT_MOVE) && held_r);

  // Root against the two radii
  always_comb begin
    dead_hit = (len <= {1'b0, dead_r});
    divisor  = (len > {1'b0, rad_r}) ? len : {1'b0, rad_r};
  end

  // Serial units
  tsrc_sqsum u_sqsum (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .mag_x (magx_nxt),
    .mag_y (magy_nxt),
    .done  (sq_done),
    .sq    (sq)
  );

  tsrc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .sq    (sq),
    .done  (rt_done),
    .root  (len)
  );

  tsrc_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dv_start),
    .mag     (magx_r),
    .divisor (divisor),
    .done    (dvx_done),
    .quot    (qx)
  );

  tsrc_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dv_start),
    .mag     (magy_r),
    .divisor (divisor),
    .done    (dvy_done),
    .quot    (qy)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = tracks ? ST_SQSUM : ST_DONE;
      ST_SQSUM:  if (sq_done) state_nxt = ST_ROOT;
      ST_ROOT:   if (rt_done) state_nxt = dead_hit ? ST_DONE : ST_DIVIDE;
      ST_DIVIDE: if (dvx_done) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    sq_start    = 1'b0;
    rt_start    = 1'b0;
    dv_start    = 1'b0;
    fire        = 1'b0;
    unique case (state_r)
      ST_IDLE:   begin
        in_ch.ready = 1'b1;
        sq_start    = in_ch.valid && tracks;
      end
      ST_SQSUM:  rt_start = sq_done;
      ST_ROOT:   dv_start = rt_done && !dead_hit;
      ST_DIVIDE: ;
      ST_DONE:   fire = out_free;
      default:   ;
    endcase
  end

  // Hold the item's kind and offset while the units run
  always_comb begin
    trk_nxt  = trk_r;
    clr_nxt  = clr_r;
    zero_nxt = zero_r;
    if (accept) begin
      trk_nxt  = tracks;
      clr_nxt  = (in_ch.action == ACT_UP);
      zero_nxt = 1'b0;
    end else if ((state_r == ST_ROOT) && rt_done) begin
      zero_nxt = dead_hit;
    end
  end

  // Update the stick when the result goes out
  always_comb begin
    held_nxt      = held_r;
    defx_nxt      = defx_r;
    defy_nxt      = defy_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (trk_r) begin
        held_nxt = 1'b1;
        if (zero_r) begin
          defx_nxt = '0;
          defy_nxt = '0;
        end else begin
          defx_nxt = sgnx_r ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
          defy_nxt = sgny_r ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        end
      end else if (clr_r) begin
        held_nxt = 1'b0;
        defx_nxt = '0;
        defy_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= 1'b0;
      defx_r      <= '0;
      defy_r      <= '0;
      out_valid_r <= 1'b0;
      trk_r       <= 1'b0;
      clr_r       <= 1'b0;
      zero_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      defx_r      <= defx_nxt;
      defy_r      <= defy_nxt;
      out_valid_r <= out_valid_nxt;
      trk_r       <= trk_nxt;
      clr_r       <= clr_nxt;
      zero_r      <= zero_nxt;
    end
    if (accept) begin
      sgnx_r <= sgnx_nxt;
      sgny_r <= sgny_nxt;
      magx_r <= magx_nxt;
      magy_r <= magy_nxt;
    end
  end

  // Stick state doubles as the output register
  assign out_ch.valid      = out_valid_r;
  assign out_ch.stick_x    = defx_r;
  assign out_ch.stick_y    = defy_r;
  assign out_ch.is_pressed = held_r;

  `TSRC_ASSERT(a_released_zero, !held_r |-> (defx_r == '0 && defy_r == '0))
  `TSRC_ASSERT(a_range_x, (defx_r <= FULL_SCALE) && (defx_r >= -FULL_SCALE))
  `TSRC_ASSERT(a_range_y, (defy_r <= FULL_SCALE) && (defy_r >= -FULL_SCALE))
  `TSRC_NEVER(a_lanes_apart, dvx_done != dvy_done)
  `TSRC_NEVER(a_sq_done_state, sq_done && (state_r != ST_SQSUM))
endmodule

FILE: test/stick_checker.sv
`timescale 1ns / 1ps
module stick_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  tsrc_in_if                             in_ch,
  tsrc_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [tsrc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tsrc_pkg::COORD_W-1:0]   cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  import tsrc_pkg::*;

  localparam int unsigned UNIT = FULL_SCALE;

  typedef struct packed {
    logic signed [STICK_W-1:0] sx;
    logic signed [STICK_W-1:0] sy;
    logic                      pressed;
  } stick_t;

  // Sticks still to come out of the block, oldest first
  stick_t awaited_sticks[$];
  stick_t got;
  stick_t want;

  // Shadow of the registers and of the stick state
  logic [COORD_W-1:0]        cen_x;
  logic [COORD_W-1:0]        cen_y;
  logic [COORD_W-1:0]        rad_stick;
  logic [COORD_W-1:0]        rad_dead;
  logic                      held;
  logic signed [STICK_W-1:0] defl_x;
  logic signed [STICK_W-1:0] defl_y;

  // Floored square root, one result bit per step from the top
  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = LEN_W - 1; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // comp * full scale / divisor, truncated toward zero, capped at full scale
  function automatic logic signed [STICK_W-1:0] scale_q14(input int comp,
                                                          input int unsigned divisor);
    int unsigned mag;
    int unsigned q;
    mag = (comp < 0) ? -comp : comp;
    if (divisor == 0) return '0;
    q = mag * UNIT / divisor;
    if (q > UNIT) q = UNIT;
    return (comp < 0) ? STICK_W'(-int'(q)) : STICK_W'(q);
  endfunction

  // Press at a point: dead zone first, then clamp to the unit direction
  task automatic follow_touch(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty);
    int          dx;
    int          dy;
    int unsigned len;
    dx = int'(tx) - int'(cen_x);
    dy = int'(ty) - int'(cen_y);
    len = floor_root(dx * dx + dy * dy);
    held = 1'b1;
    if (len <= rad_dead) begin
      defl_x = '0;
      defl_y = '0;
    end else if (len > rad_stick) begin
      defl_x = scale_q14(dx, len);
      defl_y = scale_q14(dy, len);
    end else begin
      defl_x = scale_q14(dx, rad_stick);
      defl_y = scale_q14(dy, rad_stick);
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cen_x = '0;
      cen_y = '0;
      rad_stick = STICK_RAD_RESET;
      rad_dead = '0;
      held = 1'b0;
      defl_x = '0;
      defl_y = '0;
      awaited_sticks.delete();
      fail_count = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CENTER_X:  cen_x = cfg_wdata;
          CFG_CENTER_Y:  cen_y = cfg_wdata;
          CFG_STICK_RAD: rad_stick = cfg_wdata;
          CFG_DEAD_RAD:  rad_dead = cfg_wdata;
          default: ;
        endcase
      end

      // Match each result against the oldest awaited stick
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.stick_x, out_ch.stick_y, out_ch.is_pressed};
        if (awaited_sticks.size() == 0) begin
          $error("unexpected result: stick_x %0d stick_y %0d is_pressed %0b",
                 got.sx, got.sy, got.pressed);
          fail_count++;
        end else begin
          want = awaited_sticks.pop_front();
          check_field("stick_x", want.sx, got.sx);
          check_field("stick_y", want.sy, got.sy);
          check_field("is_pressed", want.pressed, got.pressed);
        end
      end

      // Advance the stick state for each accepted item
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.action)
          ACT_DOWN: follow_touch(in_ch.touch_x, in_ch.touch_y);
          ACT_MOVE: if (held) follow_touch(in_ch.touch_x, in_ch.touch_y);
          ACT_UP: begin
            held = 1'b0;
            defl_x = '0;
            defl_y = '0;
          end
          default: ;
        endcase
        awaited_sticks.push_back('{defl_x, defl_y, held});
      end
    end
    pending = awaited_sticks.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tsrc_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int COORD_MAX = (1 << COORD_W) - 1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COORD_W-1:0]   cfg_wdata;
  logic                 steady = 1'b0;  // no idling on either side while set
  int                   fail_count;
  int                   pending;
  int                   sent = 0;

  // Register values as last written, used to aim touches
  int cen_x = 0;
  int cen_y = 0;
  int rad_stick = 128;
  int rad_dead = 0;

  tsrc_in_if  in_ch ();
  tsrc_out_if out_ch ();

  touch_stick_radial_clamp_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  stick_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_event(input logic [ACT_W-1:0] act, input int x, input int y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.touch_x <= COORD_W'(x);
    in_ch.touch_y <= COORD_W'(y);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Aim a touch: anywhere, on a zone edge along an axis, or in a square around the center
  task automatic touch_event(input logic [ACT_W-1:0] act);
    int mode;
    int reach;
    int dx;
    int dy;
    mode = $urandom_range(0, 99);
    if (mode < 20) begin
      dx = int'($urandom_range(0, COORD_MAX)) - cen_x;
      dy = int'($urandom_range(0, COORD_MAX)) - cen_y;
    end else if (mode < 35) begin
      reach = ($urandom_range(0, 1) ? rad_stick : rad_dead) + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) reach = -reach;
      dx = 0;
      dy = 0;
      if ($urandom_range(0, 1)) dx = reach;
      else dy = reach;
    end else begin
      reach = (mode < 50) ? rad_dead + 1 : ((mode < 85) ? rad_stick : 2 * rad_stick + 8);
      dx = int'($urandom_range(0, 2 * reach)) - reach;
      dy = int'($urandom_range(0, 2 * reach)) - reach;
    end
    send_event(act, clamp_coord(cen_x + dx), clamp_coord(cen_y + dy));
  endtask

  // Mostly full gestures (down, moves, up), the rest stray events
  task automatic run_gestures(input int count);
    int stop_at;
    int kind;
    stop_at = sent + count;
    while (sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        touch_event(ACT_DOWN);
        repeat ($urandom_range(0, 8)) touch_event(ACT_MOVE);
        if (kind < 72)
          send_event(ACT_UP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end else if (kind < 88) begin
        touch_event(ACT_MOVE);
      end else if (kind < 94) begin
        send_event(ACT_SPARE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end else begin
        send_event(ACT_UP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end
    end
  endtask

  // Drop valid and wait until every awaited stick has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic load_config(input int cx, input int cy, input int rs, input int rd);
    logic [CFG_IDX_W-1:0] regs[4];
    int                   vals[4];
    regs = '{CFG_CENTER_X, CFG_CENTER_Y, CFG_STICK_RAD, CFG_DEAD_RAD};
    vals = '{cx, cy, rs, rd};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= regs[i];
      cfg_wdata <= COORD_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cen_x = cx;
    cen_y = cy;
    rad_stick = rs;
    rad_dead = rd;
  endtask

  task automatic run_phase(input int cx, input int cy, input int rs, input int rd,
                           input logic calm, input int count);
    load_config(cx, cy, rs, rd);
    steady = calm;
    run_gestures(count);
    settle();
  endtask

  // Result side: stretches of ready and stall of random length
  initial begin
    int   hold_left;
    logic level;
    hold_left = 0;
    level = 1'b1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0) begin
        level = $urandom_range(0, 99) < 70;
        hold_left = level ? $urandom_range(1, 20) : pick_gap() + 1;
      end
      out_ch.ready <= level || steady;
      hold_left--;
    end
  end

  initial begin
    int rs;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_CENTER_X;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_DOWN;
    in_ch.touch_x <= '0;
    in_ch.touch_y <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: stray events while released, corners, radius edge
    send_event(ACT_MOVE, 100, 100);
    send_event(ACT_UP, 200, 300);
    send_event(ACT_SPARE, COORD_MAX, COORD_MAX);
    send_event(ACT_DOWN, 0, 0);
    send_event(ACT_MOVE, COORD_MAX, COORD_MAX);
    send_event(ACT_MOVE, 128, 0);
    send_event(ACT_MOVE, 129, 0);
    send_event(ACT_MOVE, 64, 64);
    send_event(ACT_MOVE, 0, COORD_MAX);
    send_event(ACT_MOVE, COORD_MAX, 0);
    send_event(ACT_SPARE, 0, 0);
    send_event(ACT_DOWN, 1, 1);
    send_event(ACT_UP, COORD_MAX, COORD_MAX);
    send_event(ACT_MOVE, 50, 50);
    settle();

    // Centered wide stick: negative offsets and the center itself
    load_config(2048, 2048, COORD_MAX, 0);
    send_event(ACT_DOWN, 0, 0);
    send_event(ACT_MOVE, COORD_MAX, COORD_MAX);
    send_event(ACT_MOVE, 2048, 2048);
    send_event(ACT_MOVE, 0, COORD_MAX);
    send_event(ACT_UP, 0, 0);
    settle();

    run_phase(2048, 2048, 512, 32, 1'b0, 150);
    run_phase(0, 0, COORD_MAX, 0, 1'b0, 120);
    run_phase(COORD_MAX, COORD_MAX, 1, 0, 1'b1, 120);
    // stick radius zero: every nonzero length clamps
    run_phase(COORD_MAX, 0, 0, 0, 1'b0, 100);
    // dead zone wider than the stick
    run_phase(1000, 3000, 100, 300, 1'b0, 120);
    run_phase(2048, 2048, COORD_MAX, COORD_MAX, 1'b1, 100);
    run_phase(0, COORD_MAX, COORD_MAX, COORD_MAX - 1, 1'b0, 80);
    for (int p = 0; p < 7; p++) begin
      rs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, COORD_MAX) : $urandom_range(1, 600);
      run_phase($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), rs,
                $urandom_range(0, rs / 2), p == 3, 150);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tsrc_pkg.sv
rtl/core/tsrc_in_if.sv
rtl/core/tsrc_out_if.sv
rtl/core/tsrc_sqsum.sv
rtl/core/tsrc_sqrt.sv
rtl/core/tsrc_div.sv
rtl/core/touch_stick_radial_clamp_top.sv
test/stick_checker.sv
test/tb_top.sv
